[rtl/box_filter_window_sum_top_macros.svh]
// Assertion macros used by the box filter column stage.
// Each use names a label, a property (or antecedent and consequent) and a message.
`ifndef BOX_FILTER_WINDOW_SUM_TOP_MACROS_SVH
`define BOX_FILTER_WINDOW_SUM_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BFWS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define BFWS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
`else
`define BFWS_ASSERT(lbl, prop, msg)
`define BFWS_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

[rtl/bfws_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bfws_pkg;

   localparam int MAX_RADIUS = 15;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int PIXEL_BITS = 16;

   localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
   localparam int ROW_SLOTS = 2 * MAX_RADIUS + 2;
   localparam int SLOT_BITS = $clog2(ROW_SLOTS);
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int ROW_BITS  = $clog2(MAX_HEIGHT) + 1;
   localparam int RAD_BITS  = 4;
   localparam int DIM_BITS  = 11;
   localparam int TAP_BITS  = $clog2(WIN_DEPTH);
   localparam int HS_BITS   = 21;
   localparam int CS_BITS   = 26;
   localparam int HS_ADDR_BITS = SLOT_BITS + COL_BITS;

   // input operation codes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // register indexes on the csr port
   typedef enum logic [1:0] {
      REG_RADIUS = 2'd0,
      REG_WIDTH  = 2'd1,
      REG_HEIGHT = 2'd2
   } reg_idx_type;

   // clamped configuration seen by the datapath
   typedef struct packed {
      logic [RAD_BITS-1:0] radius;
      logic [DIM_BITS-1:0] width;
      logic [DIM_BITS-1:0] height;
   } cfg_type;

   // one column update handed from the sequencer to the column stage
   typedef struct packed {
      logic                 valid;
      logic [COL_BITS-1:0]  x;
      logic [HS_BITS-1:0]   hs;
      logic [SLOT_BITS-1:0] slot_wr;
      logic [SLOT_BITS-1:0] slot_rd;
      logic                 sub_en;
      logic                 cs_zero;
      logic                 emit;
      logic [COL_BITS-1:0]  row_out;
      logic                 last;
      logic                 done;
   } take_type;

endpackage
`default_nettype wire

[rtl/box_filter_window_sum_top.sv]
// Box filter window sum over a (2r+1) x (2r+1) window, raster order.
// A result beat is registered in the column stage's op register and then in the output register.
// Throughput: 1 pixel per cycle when the output is not stalled; after the last pixel of a row
// the input is held off while the column sum memory updates the right-edge columns one per cycle.
// Reset: radius 1, 640 x 480 frame, positions zero; memories need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module box_filter_window_sum_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_operation,
   input  wire logic [bfws_pkg::PIXEL_BITS-1:0] req_pixel_value,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [bfws_pkg::CS_BITS-1:0]         rsp_box_sum,
   output logic [bfws_pkg::COL_BITS-1:0]        rsp_out_row,
   output logic [bfws_pkg::COL_BITS-1:0]        rsp_out_col,
   output logic                                 rsp_last_in_run,
   output logic                                 rsp_frame_done,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [3:0]                      csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   logic [bfws_pkg::RAD_BITS-1:0] radius_ff;
   logic [bfws_pkg::DIM_BITS-1:0] width_ff, height_ff;
   logic                          wr_en, restart, adv;
   bfws_pkg::reg_idx_type         idx;
   bfws_pkg::cfg_type             cfg;
   bfws_pkg::take_type            take;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign idx   = bfws_pkg::reg_idx_type'(csr_paddr[3:2]);

   // register writes; any write to a real register restarts the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= bfws_pkg::RAD_BITS'(1);
         width_ff  <= bfws_pkg::DIM_BITS'(640);
         height_ff <= bfws_pkg::DIM_BITS'(480);
      end else if (wr_en) begin
         unique case (idx)
            bfws_pkg::REG_RADIUS: radius_ff <= csr_pwdata[bfws_pkg::RAD_BITS-1:0];
            bfws_pkg::REG_WIDTH:  width_ff  <= csr_pwdata[bfws_pkg::DIM_BITS-1:0];
            bfws_pkg::REG_HEIGHT: height_ff <= csr_pwdata[bfws_pkg::DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      restart = 1'b0;
      unique case (idx)
         bfws_pkg::REG_RADIUS, bfws_pkg::REG_WIDTH, bfws_pkg::REG_HEIGHT: restart = wr_en;
         default: restart = 1'b0;
      endcase
   end

   // readback
   always_comb begin
      unique case (idx)
         bfws_pkg::REG_RADIUS: csr_prdata = {28'b0, radius_ff};
         bfws_pkg::REG_WIDTH:  csr_prdata = {21'b0, width_ff};
         bfws_pkg::REG_HEIGHT: csr_prdata = {21'b0, height_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // clamp frame size into 1..max
   always_comb begin
      cfg.radius = radius_ff;
      if (width_ff == '0) cfg.width = bfws_pkg::DIM_BITS'(1);
      else if (width_ff > bfws_pkg::DIM_BITS'(bfws_pkg::MAX_WIDTH))
         cfg.width = bfws_pkg::DIM_BITS'(bfws_pkg::MAX_WIDTH);
      else cfg.width = width_ff;
      if (height_ff == '0) cfg.height = bfws_pkg::DIM_BITS'(1);
      else if (height_ff > bfws_pkg::DIM_BITS'(bfws_pkg::MAX_HEIGHT))
         cfg.height = bfws_pkg::DIM_BITS'(bfws_pkg::MAX_HEIGHT);
      else cfg.height = height_ff;
   end

   bfws_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .restart         (restart),
      .adv             (adv),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_pixel_value (req_pixel_value),
      .take            (take)
   );

   bfws_col u_col (
      .clock           (clock),
      .reset           (reset),
      .take            (take),
      .adv             (adv),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_box_sum     (rsp_box_sum),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_last_in_run (rsp_last_in_run),
      .rsp_frame_done  (rsp_frame_done)
   );

endmodule
`default_nettype wire

[rtl/bfws_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
module bfws_seq (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire bfws_pkg::cfg_type              cfg,
   input  wire logic                           restart,
   input  wire logic                           adv,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_operation,
   input  wire logic [bfws_pkg::PIXEL_BITS-1:0] req_pixel_value,
   output bfws_pkg::take_type                  take
);

   typedef enum logic [1:0] {
      ST_PIXEL = 2'b01,
      ST_BURST = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [bfws_pkg::ROW_BITS-1:0]   row_ff, row_in;
   logic [bfws_pkg::COL_BITS-1:0]   col_ff, col_in;
   logic [bfws_pkg::HS_BITS-1:0]    rs_ff, rs_in;
   logic [bfws_pkg::RAD_BITS-1:0]   k_ff, k_in;
   logic [bfws_pkg::PIXEL_BITS-1:0] win_ff [0:bfws_pkg::WIN_DEPTH-1];

   logic                            accept, step, shift_en, item_end, row_end, long_burst;
   logic [bfws_pkg::PIXEL_BITS-1:0] pix, tap, push_val;
   logic [bfws_pkg::TAP_BITS-1:0]   tap_idx;
   logic [5:0]                      win_len;
   logic [bfws_pkg::DIM_BITS-1:0]   w_m1;
   logic [11:0]                     tmp, row_lim, row_p1;
   logic [bfws_pkg::HS_BITS-1:0]    rs_base, drop_main, drop_b, rs_main, rs_burst;
   logic                            main_take, burst_take, last_flag;
   logic [bfws_pkg::COL_BITS-1:0]   x_main, x_burst;

   // window geometry
   assign tap_idx    = {cfg.radius, 1'b0};
   assign tap        = win_ff[tap_idx];
   assign win_len    = {1'b0, cfg.radius, 1'b1};
   assign w_m1       = cfg.width - 11'd1;
   assign row_end    = ({1'b0, col_ff} == w_m1);
   assign long_burst = row_end && (cfg.radius != '0);

   assign req_ready = adv && (state_ff == ST_PIXEL);
   assign accept    = req_valid && req_ready;
   assign step      = adv && (state_ff == ST_BURST);
   assign shift_en  = accept || step;

   // pixel beat: update running row sum
   assign pix = (req_operation == bfws_pkg::OP_PIXEL &&
                 {1'b0, row_ff} < {1'b0, cfg.height}) ? req_pixel_value : '0;
   assign rs_base   = (col_ff == '0) ? '0 : rs_ff;
   assign drop_main = ({1'b0, col_ff} >= {5'b0, win_len}) ?
                      bfws_pkg::HS_BITS'(tap) : '0;
   assign rs_main   = rs_base - drop_main + bfws_pkg::HS_BITS'(pix);
   assign main_take = ({1'b0, col_ff} >= {7'b0, cfg.radius});
   assign x_main    = col_ff - bfws_pkg::COL_BITS'(cfg.radius);

   // right-edge burst step k
   assign tmp        = {1'b0, w_m1} + {8'b0, k_ff};
   assign drop_b     = (tmp >= {6'b0, win_len}) ? bfws_pkg::HS_BITS'(tap) : '0;
   assign rs_burst   = rs_ff - drop_b;
   assign burst_take = (tmp >= {8'b0, cfg.radius});
   assign x_burst    = bfws_pkg::COL_BITS'(tmp - {8'b0, cfg.radius});

   assign push_val = accept ? pix : '0;
   assign last_flag = (state_ff == ST_BURST) ? (k_ff == cfg.radius) : !long_burst;
   assign item_end  = (accept && !long_burst) || (step && k_ff == cfg.radius);

   // take descriptor
   always_comb begin
      take.valid   = (accept && main_take) || (step && burst_take);
      take.x       = (state_ff == ST_BURST) ? x_burst : x_main;
      take.hs      = (state_ff == ST_BURST) ? rs_burst : rs_main;
      take.slot_wr = row_ff[bfws_pkg::SLOT_BITS-1:0];
      take.slot_rd = bfws_pkg::SLOT_BITS'(row_ff - {5'b0, win_len});
      take.sub_en  = (row_ff >= {5'b0, win_len});
      take.cs_zero = (row_ff == '0);
      take.emit    = (row_ff >= {7'b0, cfg.radius});
      take.row_out = bfws_pkg::COL_BITS'(row_ff - {7'b0, cfg.radius});
      take.last    = last_flag;
      take.done    = last_flag && row_end && ({1'b0, row_ff} == row_lim - 12'd1);
   end

   // next state
   assign row_lim = {1'b0, cfg.height} + {8'b0, cfg.radius};
   assign row_p1  = {1'b0, row_ff} + 12'd1;
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      rs_in    = rs_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_PIXEL: begin
            if (accept) begin
               rs_in = rs_main;
               if (long_burst) begin
                  state_in = ST_BURST;
                  k_in     = bfws_pkg::RAD_BITS'(1);
               end
            end
         end
         ST_BURST: begin
            if (step) begin
               rs_in = rs_burst;
               k_in  = k_ff + bfws_pkg::RAD_BITS'(1);
               if (k_ff == cfg.radius) state_in = ST_PIXEL;
            end
         end
         default: state_in = ST_PIXEL;
      endcase
      if (item_end) begin
         if (row_end) begin
            col_in = '0;
            row_in = (row_p1 >= row_lim) ? '0 : bfws_pkg::ROW_BITS'(row_p1);
         end else begin
            col_in = col_ff + bfws_pkg::COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff <= ST_PIXEL;
         row_ff   <= '0;
         col_ff   <= '0;
         rs_ff    <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         rs_ff    <= rs_in;
         k_ff     <= k_in;
      end
   end

   // pixel shift line, newest at tap 0
   always_ff @(posedge clock) begin
      if (shift_en) begin
         win_ff[0] <= push_val;
         for (int j = 1; j < bfws_pkg::WIN_DEPTH; j++) win_ff[j] <= win_ff[j-1];
      end
   end

endmodule
`default_nettype wire

[rtl/bfws_col.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "box_filter_window_sum_top_macros.svh"
module bfws_col (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bfws_pkg::take_type            take,
   output logic                               adv,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [bfws_pkg::CS_BITS-1:0]       rsp_box_sum,
   output logic [bfws_pkg::COL_BITS-1:0]      rsp_out_row,
   output logic [bfws_pkg::COL_BITS-1:0]      rsp_out_col,
   output logic                               rsp_last_in_run,
   output logic                               rsp_frame_done
);

   logic [bfws_pkg::HS_BITS-1:0] hs_mem [0:(1 << bfws_pkg::HS_ADDR_BITS)-1];
   logic [bfws_pkg::CS_BITS-1:0] cs_mem [0:bfws_pkg::MAX_WIDTH-1];

   bfws_pkg::take_type              b_ff;
   logic [bfws_pkg::CS_BITS-1:0]    rd_cs_ff;
   logic [bfws_pkg::HS_BITS-1:0]    rd_hs_ff;
   logic                            fwd_valid_ff;
   logic [bfws_pkg::COL_BITS-1:0]   fwd_x_ff;
   logic [bfws_pkg::CS_BITS-1:0]    fwd_cs_ff;
   logic [bfws_pkg::HS_ADDR_BITS-1:0] fwd_ha_ff;
   logic [bfws_pkg::HS_BITS-1:0]    fwd_hv_ff;
   logic                            rsp_valid_ff;
   logic [bfws_pkg::CS_BITS-1:0]    box_ff;
   logic [bfws_pkg::COL_BITS-1:0]   row_ff, col_ff;
   logic                            last_ff, done_ff;

   logic [bfws_pkg::HS_ADDR_BITS-1:0] rd_ha, wr_ha;
   logic [bfws_pkg::CS_BITS-1:0]    cs_old, cs_in;
   logic [bfws_pkg::HS_BITS-1:0]    hs_old;

   // pipeline moves when the output register is free or being drained
   assign adv   = !rsp_valid_ff || rsp_ready;
   assign rd_ha = {take.slot_rd, take.x};
   assign wr_ha = {b_ff.slot_wr, b_ff.x};

   // read stage: registered synchronous reads
   always_ff @(posedge clock) begin
      if (adv) begin
         rd_cs_ff <= cs_mem[take.x];
         rd_hs_ff <= hs_mem[rd_ha];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) b_ff <= '0;
      else if (adv) b_ff <= take;
   end

   // modify stage with bypass of the write made by the previous op
   always_comb begin
      if (b_ff.cs_zero) cs_old = '0;
      else if (fwd_valid_ff && fwd_x_ff == b_ff.x) cs_old = fwd_cs_ff;
      else cs_old = rd_cs_ff;
      hs_old = (fwd_valid_ff && fwd_ha_ff == {b_ff.slot_rd, b_ff.x}) ? fwd_hv_ff : rd_hs_ff;
      cs_in  = cs_old - (b_ff.sub_en ? bfws_pkg::CS_BITS'(hs_old) : '0)
               + bfws_pkg::CS_BITS'(b_ff.hs);
   end

   // write back
   always_ff @(posedge clock) begin
      if (adv && b_ff.valid) begin
         cs_mem[b_ff.x] <= cs_in;
         hs_mem[wr_ha]  <= b_ff.hs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (adv) begin
         fwd_valid_ff <= b_ff.valid;
      end
      if (adv) begin
         fwd_x_ff  <= b_ff.x;
         fwd_cs_ff <= cs_in;
         fwd_ha_ff <= wr_ha;
         fwd_hv_ff <= b_ff.hs;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= b_ff.valid && b_ff.emit;
      end
      if (adv) begin
         box_ff  <= cs_in;
         row_ff  <= b_ff.row_out;
         col_ff  <= b_ff.x;
         last_ff <= b_ff.last;
         done_ff <= b_ff.done;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_box_sum     = box_ff;
   assign rsp_out_row     = row_ff;
   assign rsp_out_col     = col_ff;
   assign rsp_last_in_run = last_ff;
   assign rsp_frame_done  = done_ff;

   `BFWS_ASSERT(a_stall_holds_op, b_ff.valid && !adv |=> b_ff.valid, "column op lost during stall")
   `BFWS_ASSERT(a_beat_from_op, $rose(rsp_valid_ff) |-> $past(b_ff.valid && b_ff.emit), "beat without op")
   `BFWS_ASSERT_IMP(a_first_row_no_sub, b_ff.valid && b_ff.cs_zero, !b_ff.sub_en, "subtract in first row")

endmodule
`default_nettype wire

[dv/tb_box_filter_window_sum_top.sv]
`timescale 1ns / 1ps
module tb_box_filter_window_sum_top;

   // register addresses; the unused slot must change nothing
   localparam logic [3:0] ADDR_RADIUS = 4'(4 * bfws_pkg::REG_RADIUS);
   localparam logic [3:0] ADDR_WIDTH  = 4'(4 * bfws_pkg::REG_WIDTH);
   localparam logic [3:0] ADDR_HEIGHT = 4'(4 * bfws_pkg::REG_HEIGHT);
   localparam logic [3:0] ADDR_UNUSED = 4'd12;

   typedef struct {
      logic [bfws_pkg::CS_BITS-1:0]  box_sum;
      logic [bfws_pkg::COL_BITS-1:0] out_row;
      logic [bfws_pkg::COL_BITS-1:0] out_col;
      logic                          last_in_run;
      logic                          frame_done;
   } box_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_operation = bfws_pkg::OP_PIXEL;
   logic [bfws_pkg::PIXEL_BITS-1:0] req_pixel_value = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [bfws_pkg::CS_BITS-1:0]    rsp_box_sum;
   logic [bfws_pkg::COL_BITS-1:0]   rsp_out_row;
   logic [bfws_pkg::COL_BITS-1:0]   rsp_out_col;
   logic                            rsp_last_in_run;
   logic                            rsp_frame_done;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [3:0]                      csr_paddr = '0;
   logic [31:0]                     csr_pwdata = '0;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   box_filter_window_sum_top dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [bfws_pkg::RAD_BITS-1:0] radius_reg;
   logic [bfws_pkg::DIM_BITS-1:0] width_reg;
   logic [bfws_pkg::DIM_BITS-1:0] height_reg;
   int unsigned           row_pos;
   int unsigned           col_pos;
   longint unsigned       row_sum;
   longint unsigned       pix_line [bfws_pkg::WIN_DEPTH];
   longint unsigned       hsum_rows [bfws_pkg::ROW_SLOTS*bfws_pkg::MAX_WIDTH];
   longint unsigned       col_sums [bfws_pkg::MAX_WIDTH];
   box_result_type        expected_q [$];

   int                    mismatches = 0;
   int                    hold_off = 0;
   bit                    sender_steady = 0;
   int                    burst_left = 0;

   // ---------------- predictor ----------------
   function automatic int unsigned clamp_dim(logic [bfws_pkg::DIM_BITS-1:0] v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void add_column(int unsigned x, longint unsigned hs, int unsigned r,
                                      ref box_result_type run [$]);
      box_result_type res;
      longint unsigned cs;
      cs = col_sums[x];
      hsum_rows[(row_pos % bfws_pkg::ROW_SLOTS)*bfws_pkg::MAX_WIDTH + x] = hs;
      if (row_pos >= 2*r + 1)
         cs -= hsum_rows[((row_pos - 2*r - 1) % bfws_pkg::ROW_SLOTS)*bfws_pkg::MAX_WIDTH + x];
      cs += hs;
      col_sums[x] = cs;
      if (row_pos >= r) begin
         res.box_sum     = cs[bfws_pkg::CS_BITS-1:0];
         res.out_row     = bfws_pkg::COL_BITS'(row_pos - r);
         res.out_col     = bfws_pkg::COL_BITS'(x);
         res.last_in_run = 1'b0;
         res.frame_done  = 1'b0;
         run.push_back(res);
      end
   endfunction

   function automatic void predict_window_sums(logic op, logic [bfws_pkg::PIXEL_BITS-1:0] val);
      int unsigned r, w, h, rr, c;
      int x, drop;
      longint unsigned p;
      box_result_type run [$];
      r = radius_reg;
      w = clamp_dim(width_reg, bfws_pkg::MAX_WIDTH);
      h = clamp_dim(height_reg, bfws_pkg::MAX_HEIGHT);
      if (row_pos >= h + r || col_pos >= w) begin
         row_pos = 0; col_pos = 0; row_sum = 0;
      end
      rr = row_pos;
      c = col_pos;
      if (rr == 0 && c == 0)
         foreach (col_sums[i]) col_sums[i] = 0;
      p = (op == bfws_pkg::OP_PIXEL && rr < h) ? val : 0;
      if (c == 0) row_sum = 0;
      if (c >= 2*r + 1) row_sum -= pix_line[(c - 2*r - 1) % bfws_pkg::WIN_DEPTH];
      pix_line[c % bfws_pkg::WIN_DEPTH] = p;
      row_sum += p;
      if (c >= r) add_column(c - r, row_sum, r, run);
      // right edge: windows that reach past the last column
      if (c == w - 1) begin
         for (int k = 1; k <= r; k++) begin
            x = int'(w) - 1 - int'(r) + k;
            drop = x - int'(r) - 1;
            if (drop >= 0) row_sum -= pix_line[drop % bfws_pkg::WIN_DEPTH];
            if (x >= 0) add_column(x, row_sum, r, run);
         end
      end
      if (run.size() > 0) begin
         run[run.size()-1].last_in_run = 1'b1;
         if (rr == h + r - 1 && c == w - 1) run[run.size()-1].frame_done = 1'b1;
      end
      foreach (run[i]) expected_q.push_back(run[i]);
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (rr + 1 >= h + r) ? 0 : rr + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      box_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected beat sum=%0d row=%0d col=%0d",
                        rsp_box_sum, rsp_out_row, rsp_out_col);
         end else begin
            e = expected_q.pop_front();
            if (rsp_box_sum !== e.box_sum || rsp_out_row !== e.out_row ||
                rsp_out_col !== e.out_col || rsp_last_in_run !== e.last_in_run ||
                rsp_frame_done !== e.frame_done) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"ERROR: exp sum=%0d row=%0d col=%0d last=%0b done=%0b, ",
                            "got sum=%0d row=%0d col=%0d last=%0b done=%0b"},
                           e.box_sum, e.out_row, e.out_col, e.last_in_run, e.frame_done,
                           rsp_box_sum, rsp_out_row, rsp_out_col, rsp_last_in_run,
                           rsp_frame_done);
            end
         end
      end
   end

   // ---------------- receiver stall pattern ----------------
   initial begin
      int mode, phase;
      mode = 0;
      phase = 0;
      forever begin
         @(negedge clock);
         if (phase == 0) begin
            mode = $urandom_range(0, 3);
            phase = $urandom_range(16, 80);
         end
         phase--;
         if (hold_off > 0) begin
            hold_off--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 9) < 7);
               2: rsp_ready <= phase[1];
               default: rsp_ready <= ($urandom_range(0, 9) < 2);
            endcase
         end
      end
   end

   // ---------------- sender ----------------
   task automatic send_pixel(logic op, logic [bfws_pkg::PIXEL_BITS-1:0] val);
      if (!sender_steady && burst_left == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_pixel_value <= val;
      do @(posedge clock); while (!req_ready);
      predict_window_sums(op, val);
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() > 0) @(posedge clock);
      // bursts with no emitted beats may still be running
      repeat (2 * bfws_pkg::MAX_RADIUS + 8) @(posedge clock);
   endtask

   task automatic write_reg(logic [3:0] addr, logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (addr)
         ADDR_RADIUS: radius_reg = data[bfws_pkg::RAD_BITS-1:0];
         ADDR_WIDTH:  width_reg  = data[bfws_pkg::DIM_BITS-1:0];
         ADDR_HEIGHT: height_reg = data[bfws_pkg::DIM_BITS-1:0];
         default: ;
      endcase
      if (addr == ADDR_RADIUS || addr == ADDR_WIDTH || addr == ADDR_HEIGHT) begin
         row_pos = 0; col_pos = 0; row_sum = 0;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_frame(int r, int w, int h);
      wait_results_drained();
      write_reg(ADDR_RADIUS, r);
      write_reg(ADDR_WIDTH, w);
      write_reg(ADDR_HEIGHT, h);
   endtask

   function automatic logic [bfws_pkg::PIXEL_BITS-1:0] rand_pixel();
      return bfws_pkg::PIXEL_BITS'($urandom_range(0, 65535));
   endfunction

   // one complete frame: pixels in real rows, drains in the flush rows, mess_pct percent of ops flipped
   task automatic send_frame(int mess_pct);
      int unsigned r, w, h;
      logic op;
      r = radius_reg;
      w = clamp_dim(width_reg, bfws_pkg::MAX_WIDTH);
      h = clamp_dim(height_reg, bfws_pkg::MAX_HEIGHT);
      for (int y = 0; y < h + r; y++)
         for (int x = 0; x < w; x++) begin
            op = (y < h) ? bfws_pkg::OP_PIXEL : bfws_pkg::OP_DRAIN;
            if ($urandom_range(0, 99) < mess_pct) op = ~op;
            send_pixel(op, rand_pixel());
         end
   endtask

   // ---------------- tests ----------------
   task automatic test_reset_config();
      // default 640 wide, radius 1: partial frame only
      for (int i = 0; i < 12; i++) send_pixel(bfws_pkg::OP_PIXEL, rand_pixel());
   endtask

   task automatic test_directed();
      // all-max and all-zero pixels, drain inside a real row, pixel inside a drain row
      set_frame(1, 4, 3);
      for (int i = 0; i < 8; i++) send_pixel(bfws_pkg::OP_PIXEL, 16'hFFFF);
      send_pixel(bfws_pkg::OP_DRAIN, 16'hFFFF);
      send_pixel(bfws_pkg::OP_PIXEL, 16'h0000);
      send_pixel(bfws_pkg::OP_PIXEL, 16'h5555);
      send_pixel(bfws_pkg::OP_PIXEL, 16'hAAAA);
      send_pixel(bfws_pkg::OP_PIXEL, 16'hFFFF);
      send_pixel(bfws_pkg::OP_DRAIN, 16'h0);
      send_pixel(bfws_pkg::OP_DRAIN, 16'h0);
      send_pixel(bfws_pkg::OP_DRAIN, 16'h0);
      // zero radius, one-pixel frame
      set_frame(0, 1, 1);
      send_pixel(bfws_pkg::OP_PIXEL, 16'hFFFF);
      send_pixel(bfws_pkg::OP_PIXEL, 16'h1234);
      // widest radius on a tiny frame: windows clipped on all sides
      set_frame(bfws_pkg::MAX_RADIUS, 2, 1);
      send_frame(0);
      // out-of-range sizes clamp to the maximum; partial frame with upper bits set
      set_frame(2, 32'hFFFF_F7FF, 32'h0000_07FF);
      for (int i = 0; i < 20; i++) send_pixel(bfws_pkg::OP_PIXEL, 16'hFFFF);
      // zero width clamps to one
      set_frame(1, 0, 2);
      send_frame(0);
      // unused register slot must not restart the frame
      set_frame(1, 3, 2);
      send_pixel(bfws_pkg::OP_PIXEL, 16'h00FF);
      send_pixel(bfws_pkg::OP_PIXEL, 16'hFF00);
      wait_results_drained();
      write_reg(ADDR_UNUSED, 32'hFFFF_FFFF);
      for (int i = 0; i < 10; i++) send_pixel(bfws_pkg::OP_PIXEL, rand_pixel());
   endtask

   task automatic test_random_frames();
      int sent, r, w, h;
      sent = 0;
      while (sent < 110) begin
         sender_steady = ($urandom_range(0, 3) == 0);
         r = ($urandom_range(0, 5) == 0) ? $urandom_range(0, bfws_pkg::MAX_RADIUS) :
                                           $urandom_range(0, 3);
         w = $urandom_range(1, 10);
         h = $urandom_range(1, 6);
         if (r > 4 && w > 4) w = $urandom_range(1, 4);
         set_frame(r, w, h);
         if ($urandom_range(0, 4) == 0) begin
            // abandoned partial frame
            for (int i = 0; i < w * h / 2 + 1; i++)
               send_pixel(bfws_pkg::OP_PIXEL, rand_pixel());
            sent += w * h / 2 + 1;
         end else begin
            send_frame($urandom_range(0, 1) ? 10 : 0);
            sent += w * (h + r);
         end
      end
      sender_steady = 0;
   endtask

   task automatic test_backpressure();
      set_frame(3, 8, 2);
      sender_steady = 1;
      hold_off = 300;
      send_frame(0);
      // sender waits until everything is out, then runs again
      wait_results_drained();
      send_frame(0);
      sender_steady = 0;
   endtask

   // ---------------- main ----------------
   initial begin
      radius_reg = 1;
      width_reg  = 640;
      height_reg = 480;
      row_pos = 0; col_pos = 0; row_sum = 0;
      foreach (pix_line[i]) pix_line[i] = 0;
      foreach (col_sums[i]) col_sums[i] = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_config();
      test_directed();
      test_random_frames();
      test_backpressure();
      wait_results_drained();
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/bfws_pkg.sv
rtl/bfws_seq.sv
rtl/bfws_col.sv
rtl/box_filter_window_sum_top.sv
dv/tb_box_filter_window_sum_top.sv
